// File: sv/assert_macros.svh
// Assertion macros shared by the LBP stream RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on the rising edge, ignored while reset is high
`define LBP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// Check a property on every rising edge, reset included
`define LBP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define LBP_ASSERT(lbl, clk, rst, prop)
`define LBP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: sv/lbp3_pkg.sv
// Package for the uniform LBP 3x3 stream: sizes, register indexes, item types
// and the uniform-pattern lookup table. No dependencies.
package lbp3_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MIN_SIZE     = 3;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;
  localparam int INDEX_W      = 6;
  localparam int MAX_INDEX    = 58;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  LINE_WIDTH_RESET   = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // Item passed from the front end to the back end
  typedef struct packed {
    logic [7:0]       pixel;
    logic [COL_W-1:0] col;
    logic             centre_valid;
    logic             frame_done;
  } q_item_t;

  // Result item
  typedef struct packed {
    logic [INDEX_W-1:0] pattern_index;
    logic               centre_valid;
    logic               frame_done;
  } result_t;

  typedef logic [INDEX_W-1:0] uni_table_t [256];

  // Build the code-to-index table: codes with at most two circular bit
  // changes get 1..58 in ascending order, all others get 0.
  function automatic uni_table_t build_uni_table();
    uni_table_t         t;
    logic [INDEX_W-1:0] nxt;
    logic [7:0]         c;
    int                 changes;
    nxt = 6'd1;
    for (int code = 0; code < 256; code++) begin
      c = 8'(code);
      changes = 0;
      for (int k = 0; k < 8; k++) begin
        if (c[k] != c[(k + 1) & 7]) changes++;
      end
      if (changes <= 2) begin
        t[code] = nxt;
        nxt = nxt + 6'd1;
      end else begin
        t[code] = '0;
      end
    end
    return t;
  endfunction

  localparam uni_table_t UNI_TABLE = build_uni_table();

endpackage

// File: sv/lbp3_if.sv
// Valid/ready channel interfaces for pixel items and pattern result items.
// Depends on lbp3_pkg for field widths.
interface lbp3_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface lbp3_pattern_if;
  logic                             valid;
  logic                             ready;
  logic [lbp3_pkg::INDEX_W-1:0]     pattern_index;
  logic                             centre_valid;
  logic                             frame_done;

  modport source (output valid, output pattern_index, output centre_valid,
                  output frame_done, input ready);
  modport sink (input valid, input pattern_index, input centre_valid,
                input frame_done, output ready);
endinterface

// File: sv/uniform_lbp_3x3_stream.sv
// Top level of the uniform LBP (8 neighbours, radius 1, 59 bins) pixel stream.
// Pixels pass the queue, the item register and the output register; 1 pixel
// per cycle unless the output stalls, set by one line store read and write per item.
// One result per pixel; a 2-entry queue decouples position tracking from windowing.
// Reset (rst, synchronous, high) clears counters, window and queue, and loads
// line_width 640 and frame_height 480; the line store is not cleared.
module uniform_lbp_3x3_stream (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lbp3_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lbp3_pkg::CFG_DATA_W-1:0]  cfg_data,
  lbp3_pixel_if.sink                       pixels,
  lbp3_pattern_if.source                   patterns
);

  logic              q_full;
  logic              q_push;
  lbp3_pkg::q_item_t q_in;
  logic              q_pop;
  logic              q_avail;
  lbp3_pkg::q_item_t q_out;
  lbp3_pkg::result_t res;

  lbp3_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (pixels.valid),
    .in_pixel       (pixels.pixel),
    .in_frame_start (pixels.frame_start),
    .in_ready       (pixels.ready),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  lbp3_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .avail     (q_avail)
  );

  lbp3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (patterns.valid),
    .out_ready (patterns.ready),
    .out_data  (res)
  );

  // Unpack the result item onto the channel
  assign patterns.pattern_index = res.pattern_index;
  assign patterns.centre_valid  = res.centre_valid;
  assign patterns.frame_done    = res.frame_done;

endmodule

// File: sv/lbp3_front.sv
// Front end: configuration registers, row/column tracking and item classification.
// Depends on lbp3_pkg.
module lbp3_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lbp3_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lbp3_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  input  logic [7:0]                         in_pixel,
  input  logic                               in_frame_start,
  output logic                               in_ready,
  input  logic                               q_full,
  output logic                               q_push,
  output lbp3_pkg::q_item_t                  q_item
);

  logic [lbp3_pkg::WIDTH_REG_W-1:0]  line_width;
  logic [lbp3_pkg::HEIGHT_REG_W-1:0] frame_height;
  logic [lbp3_pkg::COL_W-1:0]        col_cnt;
  logic [lbp3_pkg::ROW_W-1:0]        row_cnt;

  logic [lbp3_pkg::WIDTH_REG_W-1:0]  w;
  logic [lbp3_pkg::HEIGHT_REG_W-1:0] h;
  logic [lbp3_pkg::COL_W-1:0]        c0;
  logic [lbp3_pkg::COL_W-1:0]        col;
  logic [lbp3_pkg::ROW_W:0]          r0;
  logic [lbp3_pkg::ROW_W:0]          r1;
  logic [lbp3_pkg::ROW_W-1:0]        row;
  logic [lbp3_pkg::COL_W:0]          colp;
  logic [lbp3_pkg::ROW_W:0]          rowp;
  logic                              centre_valid;
  logic                              accept;

  // Clamp the frame size to the supported range
  always_comb begin
    if (line_width < lbp3_pkg::WIDTH_REG_W'(lbp3_pkg::MIN_SIZE)) begin
      w = lbp3_pkg::WIDTH_REG_W'(lbp3_pkg::MIN_SIZE);
    end else if (line_width > lbp3_pkg::WIDTH_REG_W'(lbp3_pkg::MAX_WIDTH)) begin
      w = lbp3_pkg::WIDTH_REG_W'(lbp3_pkg::MAX_WIDTH);
    end else begin
      w = line_width;
    end
    if (frame_height < lbp3_pkg::HEIGHT_REG_W'(lbp3_pkg::MIN_SIZE)) begin
      h = lbp3_pkg::HEIGHT_REG_W'(lbp3_pkg::MIN_SIZE);
    end else if (frame_height > lbp3_pkg::HEIGHT_REG_W'(lbp3_pkg::MAX_HEIGHT)) begin
      h = lbp3_pkg::HEIGHT_REG_W'(lbp3_pkg::MAX_HEIGHT);
    end else begin
      h = frame_height;
    end
  end

  // Place the incoming pixel: frame start, row wrap, frame wrap
  always_comb begin
    c0 = in_frame_start ? '0 : col_cnt;
    r0 = in_frame_start ? '0 : {1'b0, row_cnt};
    if ({1'b0, c0} >= w) begin
      col = '0;
      r1  = r0 + (lbp3_pkg::ROW_W + 1)'(1);
    end else begin
      col = c0;
      r1  = r0;
    end
    row  = ({1'b0, r1[lbp3_pkg::ROW_W-1:0]} >= h || r1[lbp3_pkg::ROW_W]) ?
           '0 : r1[lbp3_pkg::ROW_W-1:0];
    colp = {1'b0, col} + (lbp3_pkg::COL_W + 1)'(1);
    rowp = {1'b0, row} + (lbp3_pkg::ROW_W + 1)'(1);
  end

  // Classify the window centre and build the queue item
  always_comb begin
    centre_valid = (row >= lbp3_pkg::ROW_W'(2)) && (col >= lbp3_pkg::COL_W'(2));
    q_item.pixel        = in_pixel;
    q_item.col          = col;
    q_item.centre_valid = centre_valid;
    q_item.frame_done   = centre_valid &&
                          ({1'b0, row} == h - lbp3_pkg::HEIGHT_REG_W'(1)) &&
                          ({1'b0, col} == w - lbp3_pkg::WIDTH_REG_W'(1));
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= lbp3_pkg::LINE_WIDTH_RESET;
      frame_height <= lbp3_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lbp3_pkg::REG_LINE_WIDTH:   line_width   <= cfg_data[lbp3_pkg::WIDTH_REG_W-1:0];
        lbp3_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the position counters on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (colp >= w) begin
        col_cnt <= '0;
        row_cnt <= (rowp >= h) ? '0 : rowp[lbp3_pkg::ROW_W-1:0];
      end else begin
        col_cnt <= colp[lbp3_pkg::COL_W-1:0];
        row_cnt <= row;
      end
    end
  end

endmodule

// File: sv/lbp3_fifo.sv
// Two-entry queue between the front end and the back end.
// Depends on lbp3_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lbp3_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lbp3_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output lbp3_pkg::q_item_t pop_item,
  output logic              avail
);

  lbp3_pkg::q_item_t entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full     = (count == 2'd2);
  assign avail    = (count != 2'd0);
  assign pop_item = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `LBP_ASSERT(a_count_bound, clk, rst, count <= 2'd2)
  `LBP_ASSERT(a_no_overflow, clk, rst, !(push && full && !pop))
  `LBP_ASSERT(a_no_underflow, clk, rst, pop |-> count != 2'd0)
  `LBP_ASSERT(a_fill_step, clk, rst, (push && !pop) |=> count == $past(count) + 2'd1)

endmodule

// File: sv/lbp3_back.sv
// Back end: line store, 3x3 window, neighbour compare, table lookup, output register.
// Depends on lbp3_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lbp3_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_avail,
  input  lbp3_pkg::q_item_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output lbp3_pkg::result_t out_data
);

  // Line store: upper byte holds the previous row, lower byte the row before
  logic [15:0]                line_mem [lbp3_pkg::MAX_WIDTH];
  logic [15:0]                rd_data;

  logic                       b_full;
  lbp3_pkg::q_item_t          b_item;
  logic                       b_adv;

  logic                       fwd_valid;
  logic [lbp3_pkg::COL_W-1:0] fwd_addr;
  logic [15:0]                fwd_data;

  logic [7:0]                 win [6];
  logic                       o_full;

  logic [15:0]                stored;
  logic [7:0]                 top;
  logic [7:0]                 mid;
  logic [7:0]                 bot;
  logic [7:0]                 centre;
  logic [7:0]                 code;
  lbp3_pkg::result_t          res;

  assign b_adv     = b_full && (!o_full || out_ready);
  assign q_pop     = q_avail && (!b_full || b_adv);
  assign out_valid = o_full;

  // Pick the latest column data: forward the last write over a stale read
  always_comb begin
    stored = (fwd_valid && fwd_addr == b_item.col) ? fwd_data : rd_data;
    mid    = stored[15:8];
    top    = stored[7:0];
    bot    = b_item.pixel;
    centre = win[1];
  end

  // Compare the eight neighbours with the centre and look up the index
  always_comb begin
    code[0] = win[4] >= centre;
    code[1] = win[5] >= centre;
    code[2] = win[2] >= centre;
    code[3] = bot    >= centre;
    code[4] = mid    >= centre;
    code[5] = top    >= centre;
    code[6] = win[0] >= centre;
    code[7] = win[3] >= centre;
    res.centre_valid  = b_item.centre_valid;
    res.frame_done    = b_item.centre_valid && b_item.frame_done;
    res.pattern_index = b_item.centre_valid ? lbp3_pkg::UNI_TABLE[code] : '0;
  end

  // Read the line store on pop, shift the column down on completion
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data <= line_mem[q_item.col];
    end
    if (b_adv) begin
      line_mem[b_item.col] <= {bot, mid};
    end
  end

  // Hold the item under work and the last write for forwarding
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_item <= q_item;
    end
    if (b_adv) begin
      fwd_addr <= b_item.col;
      fwd_data <= {bot, mid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_full    <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        b_full <= 1'b1;
      end else if (b_adv) begin
        b_full <= 1'b0;
      end
      if (b_adv) fwd_valid <= 1'b1;
    end
  end

  // Shift the 3x3 window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (b_adv) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= top;
      win[1] <= mid;
      win[2] <= bot;
    end
  end

  // Output register: load on completion, drop when taken
  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_full <= 1'b0;
    end else if (b_adv) begin
      o_full <= 1'b1;
    end else if (out_ready) begin
      o_full <= 1'b0;
    end
  end

  `LBP_ASSERT(a_no_window_no_index, clk, rst,
    (o_full && !out_data.centre_valid) |-> (out_data.pattern_index == '0 && !out_data.frame_done))
  `LBP_ASSERT(a_index_range, clk, rst,
    o_full |-> out_data.pattern_index <= lbp3_pkg::INDEX_W'(lbp3_pkg::MAX_INDEX))
  `LBP_ASSERT(a_stall_holds_item, clk, rst,
    (b_full && !b_adv) |=> (b_full && $stable(b_item) && $stable(rd_data)))
  `LBP_ASSERT(a_done_on_last_column, clk, rst,
    (b_adv && b_item.frame_done) |-> b_item.centre_valid)

endmodule

// File: test/tb_top.sv
// Testbench for uniform_lbp_3x3_stream: directed 3x3 frames, then random raster frames
// under several register settings and idle/stall mixes, checked by a scoreboard class.
// Depends on lbp3_pkg, lbp3_pixel_if / lbp3_pattern_if and the block itself.
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int NUM_PHASES  = 10;

  // Scoreboard: tracks window state, predicts one pattern item per pixel item
  class lbp_scoreboard;
    bit [5:0]                        uniform_index [256];
    bit [7:0]                        recent_line [lbp3_pkg::MAX_WIDTH];
    bit [7:0]                        older_line [lbp3_pkg::MAX_WIDTH];
    // previous column (p_*) and the one before it (q_*)
    bit [7:0]                        p_top, p_mid, p_bot, q_top, q_mid, q_bot;
    bit [lbp3_pkg::WIDTH_REG_W-1:0]  width_reg;
    bit [lbp3_pkg::HEIGHT_REG_W-1:0] height_reg;
    int unsigned                     col_cnt, row_cnt;
    lbp3_pkg::result_t               expected_patterns [$];
    int                              mismatches;

    function new();
      bit [7:0] v;
      bit [5:0] next_idx;
      next_idx = 6'd1;
      // Number the codes with at most two circular transitions in ascending order
      for (int code = 0; code < 256; code++) begin
        v = 8'(code);
        if ($countones(v ^ {v[0], v[7:1]}) <= 2) begin
          uniform_index[code] = next_idx;
          next_idx++;
        end else begin
          uniform_index[code] = 6'd0;
        end
      end
      width_reg  = lbp3_pkg::LINE_WIDTH_RESET;
      height_reg = lbp3_pkg::FRAME_HEIGHT_RESET;
      col_cnt    = 0;
      row_cnt    = 0;
      {p_top, p_mid, p_bot, q_top, q_mid, q_bot} = '0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned line_span();
      return clamp_size(width_reg, lbp3_pkg::MIN_SIZE, lbp3_pkg::MAX_WIDTH);
    endfunction

    function bit at_frame_origin();
      return (col_cnt == 0) && (row_cnt == 0);
    endfunction

    function int outstanding();
      return expected_patterns.size();
    endfunction

    function void set_register(logic [lbp3_pkg::CFG_INDEX_W-1:0] idx,
                               logic [lbp3_pkg::CFG_DATA_W-1:0] data);
      if (idx == lbp3_pkg::REG_LINE_WIDTH) begin
        width_reg = data[lbp3_pkg::WIDTH_REG_W-1:0];
      end else if (idx == lbp3_pkg::REG_FRAME_HEIGHT) begin
        height_reg = data[lbp3_pkg::HEIGHT_REG_W-1:0];
      end
    endfunction

    // Predict the pattern item caused by one accepted pixel item
    function void predict_pattern(bit [7:0] bot, bit fs);
      int unsigned       w, h, col, row;
      bit [7:0]          top, mid, c, code;
      lbp3_pkg::result_t r;
      w = line_span();
      h = clamp_size(height_reg, lbp3_pkg::MIN_SIZE, lbp3_pkg::MAX_HEIGHT);
      if (fs) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      // Counts left beyond a shrunk size start a new row or a new frame
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      col = col_cnt;
      row = row_cnt;

      top = older_line[col];
      mid = recent_line[col];
      older_line[col]  = mid;
      recent_line[col] = bot;

      r = '0;
      if (row >= 2 && col >= 2) begin
        c = p_mid;
        code = {q_top >= c, p_top >= c, top >= c, mid >= c,
                bot >= c, p_bot >= c, q_bot >= c, q_mid >= c};
        r.pattern_index = uniform_index[code];
        r.centre_valid  = 1'b1;
        r.frame_done    = (row == h - 1) && (col == w - 1);
      end

      {q_top, q_mid, q_bot} = {p_top, p_mid, p_bot};
      {p_top, p_mid, p_bot} = {top, mid, bot};

      // Advance position, wrapping at the end of a row and of a frame
      col_cnt = col + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = row + 1;
        if (row_cnt >= h) row_cnt = 0;
      end
      expected_patterns.insert(expected_patterns.size(), r);
    endfunction

    // Compare one accepted pattern item with the oldest prediction
    function void check_pattern(lbp3_pkg::result_t got);
      lbp3_pkg::result_t want;
      if (expected_patterns.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual index %0d valid %0b done %0b",
                 $time, got.pattern_index, got.centre_valid, got.frame_done);
        mismatches++;
        return;
      end
      want = expected_patterns.pop_front();
      if (got.pattern_index !== want.pattern_index) begin
        $display("%0t: pattern_index expected %0d actual %0d",
                 $time, want.pattern_index, got.pattern_index);
        mismatches++;
      end
      if (got.centre_valid !== want.centre_valid) begin
        $display("%0t: centre_valid expected %0b actual %0b",
                 $time, want.centre_valid, got.centre_valid);
        mismatches++;
      end
      if (got.frame_done !== want.frame_done) begin
        $display("%0t: frame_done expected %0b actual %0b",
                 $time, want.frame_done, got.frame_done);
        mismatches++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [lbp3_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lbp3_pkg::CFG_DATA_W-1:0]  cfg_data;

  lbp3_pixel_if   pix_ch ();
  lbp3_pattern_if pat_ch ();

  lbp_scoreboard     board;
  lbp3_pkg::result_t seen;
  int                cycle_count = 0;
  int unsigned       sender_idle_pct = 0;
  int unsigned       receiver_stall_pct = 0;
  int                hold_requests = 0;
  int                hold_served = 0;
  int                hold_left = 0;
  bit [7:0]          drift_level = 8'd128;
  bit [7:0]          last_px = 8'd0;

  // Three 3x3 frames: lone bright centre, alternating ring, flat white
  bit [7:0] directed_px [27] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd200, 8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd255, 8'd0,   8'd255, 8'd100, 8'd255, 8'd0,   8'd255, 8'd0,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};

  // Random phases: width data, height data, pixel item count
  bit [lbp3_pkg::CFG_DATA_W-1:0] phase_width [NUM_PHASES] = '{
    13'h1805, 13'd0, 13'd16, 13'd2047, 13'd9, 13'd12, 13'd6, 13'd4, 13'd3, 13'd20};
  bit [lbp3_pkg::CFG_DATA_W-1:0] phase_height [NUM_PHASES] = '{
    13'd4, 13'd1, 13'd6, 13'd3, 13'd8191, 13'd10, 13'd4, 13'd5, 13'd4096, 13'd3};
  int phase_items [NUM_PHASES] = '{120, 90, 130, 200, 120, 100, 100, 100, 90, 120};

  uniform_lbp_3x3_stream dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_ch),
    .patterns  (pat_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_ch.valid && pix_ch.ready) board.predict_pattern(pix_ch.pixel, pix_ch.frame_start);
      if (pat_ch.valid && pat_ch.ready) begin
        seen.pattern_index = pat_ch.pattern_index;
        seen.centre_valid  = pat_ch.centre_valid;
        seen.frame_done    = pat_ch.frame_done;
        board.check_pattern(seen);
      end
    end
  end

  // Drive ready: a requested hold-off first, random stalls otherwise
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pat_ch.ready = 1'b0;
    end else begin
      pat_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offer one pixel item after random idle cycles; return at the next falling edge
  task automatic send_pixel(bit [7:0] px, bit fs);
    while ($urandom_range(99) < sender_idle_pct) begin
      pix_ch.valid = 1'b0;
      @(negedge clk);
    end
    pix_ch.valid       = 1'b1;
    pix_ch.pixel       = px;
    pix_ch.frame_start = fs;
    do begin
      @(posedge clk);
    end while (pix_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted item has come out
  task automatic settle();
    pix_ch.valid = 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers back to back; flag a wider line
  task automatic configure(bit [lbp3_pkg::CFG_DATA_W-1:0] width_data,
                           bit [lbp3_pkg::CFG_DATA_W-1:0] height_data, output bit grew);
    int unsigned old_span;
    old_span  = board.line_span();
    cfg_we    = 1'b1;
    cfg_index = lbp3_pkg::REG_LINE_WIDTH;
    cfg_data  = width_data;
    @(posedge clk);
    board.set_register(lbp3_pkg::REG_LINE_WIDTH, width_data);
    @(negedge clk);
    cfg_index = lbp3_pkg::REG_FRAME_HEIGHT;
    cfg_data  = height_data;
    @(posedge clk);
    board.set_register(lbp3_pkg::REG_FRAME_HEIGHT, height_data);
    @(negedge clk);
    cfg_we = 1'b0;
    grew = board.line_span() > old_span;
  endtask

  // Mix of noise, slowly drifting texture with ties, extremes and repeats
  function automatic bit [7:0] pick_pixel();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel <= 3) begin
      last_px = 8'($urandom_range(255));
    end else if (sel <= 6) begin
      drift_level = drift_level + 8'($urandom_range(2)) - 8'd1;
      last_px = drift_level + 8'($urandom_range(3));
    end else if (sel <= 8) begin
      last_px = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return last_px;
  endfunction

  // Raster frames; frame_start mostly at frame origin, rarely mid-frame
  task automatic stream_pixels(int count, bit restart);
    bit fs;
    for (int i = 0; i < count; i++) begin
      fs = 1'b0;
      if (i == 0 && restart) fs = 1'b1;
      else if (board.at_frame_origin() && $urandom_range(1) == 1) fs = 1'b1;
      else if ($urandom_range(299) == 0) fs = 1'b1;
      send_pixel(pick_pixel(), fs);
    end
  endtask

  initial begin
    bit grew;
    board = new();
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = lbp3_pkg::REG_LINE_WIDTH;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel       = '0;
    pix_ch.frame_start = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frames at the smallest size; the middle one wraps without frame_start
    configure(13'd3, 13'd3, grew);
    for (int i = 0; i < 27; i++) send_pixel(directed_px[i], i == 0 || i == 18);
    settle();

    // Random phases, cycling through the idle/stall mixes
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
        default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
      endcase
      configure(phase_width[p], phase_height[p], grew);
      // Hold the output off while items keep coming, so the input backs up
      if (p == 4 || p == 8) hold_requests++;
      stream_pixels(phase_items[p], grew);
      settle();
    end

    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
